### sv/tas_pkg.sv
// ----------------------------------------------------------------------------
// tas_pkg
// Shared types and constants of the trapezoid angle sweep core.
// ----------------------------------------------------------------------------
package tas_pkg;

    localparam int AngleW   = 16;
    localparam int TickW    = 16;
    localparam int PhaseW   = 18;
    localparam int DvdW     = PhaseW + 1;
    localparam int CntW     = 5;

    // Iterations of the shared restoring divider
    localparam logic [CntW-1:0] ModSteps  = CntW'(DvdW);
    localparam logic [CntW-1:0] LerpSteps = CntW'(TickW);

    // Configuration register indexes
    localparam logic [1:0] REG_START_ANGLE = 2'd0;
    localparam logic [1:0] REG_END_ANGLE   = 2'd1;
    localparam logic [1:0] REG_RAMP_TICKS  = 2'd2;
    localparam logic [1:0] REG_DWELL_TICKS = 2'd3;

    // Segment codes
    localparam logic [1:0] SEG_DWELL_START = 2'd0;
    localparam logic [1:0] SEG_RAMP_UP     = 2'd1;
    localparam logic [1:0] SEG_DWELL_END   = 2'd2;
    localparam logic [1:0] SEG_RAMP_BACK   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_CLASSIFY,
        ST_MULT,
        ST_LERP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;          // take a request, start the phase sum
        logic div_step;      // one restoring divider iteration
        logic div_sel_ramp;  // divide by ramp_ticks instead of the period
        logic classify;      // store phase, pick segment and ramp offset
        logic mult;          // form |diff| * offset, seed the divider
        logic finish;        // build the angle into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic period_zero;
        logic ramp_hit;
    } dp_status_t;

endpackage

### sv/tas_datapath.sv
// ----------------------------------------------------------------------------
// tas_datapath
// Configuration, phase, shared serial divider, multiplier and output register.
// ----------------------------------------------------------------------------
module tas_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [tas_pkg::AngleW-1:0]    cfg_data,
    input  logic [tas_pkg::TickW-1:0]     elapsed_ticks,
    input  tas_pkg::dp_cmd_t              cmd,
    output tas_pkg::dp_status_t           status,
    output logic [tas_pkg::AngleW-1:0]    angle_out,
    output logic [1:0]                    segment
);

    logic [tas_pkg::AngleW-1:0] start_reg;
    logic [tas_pkg::AngleW-1:0] end_reg;
    logic [tas_pkg::TickW-1:0]  ramp_reg;
    logic [tas_pkg::TickW-1:0]  dwell_reg;
    logic [tas_pkg::PhaseW-1:0] phase_reg;

    logic [tas_pkg::PhaseW-1:0] rem_reg;
    logic [tas_pkg::DvdW-1:0]   dvd_reg;
    logic [1:0]                 seg_reg;
    logic [tas_pkg::TickW-1:0]  offset_reg;
    logic                       neg_reg;
    logic [tas_pkg::AngleW-1:0] angle_reg;
    logic [1:0]                 out_seg_reg;

    logic [tas_pkg::PhaseW-1:0] period;
    logic [tas_pkg::DvdW-1:0]   divisor;
    logic [tas_pkg::DvdW-1:0]   trial;
    logic                       trial_ge;
    logic [tas_pkg::DvdW-1:0]   trial_diff;

    logic [tas_pkg::TickW:0]    dr_sum;
    logic [tas_pkg::PhaseW-1:0] end2;
    logic [1:0]                 cls_seg;
    logic [tas_pkg::PhaseW-1:0] cls_off;

    logic [tas_pkg::AngleW:0]   diff;
    logic [tas_pkg::AngleW:0]   diff_abs;
    logic [2*tas_pkg::TickW-1:0] prod;

    logic [tas_pkg::TickW:0]    part;
    logic [tas_pkg::AngleW:0]   angle_sum;

    assign period = {1'b0, ramp_reg, 1'b0} + {1'b0, dwell_reg, 1'b0};

    // Divider iteration: shift one dividend bit into the partial remainder
    assign divisor    = cmd.div_sel_ramp ? {3'b000, ramp_reg} : {1'b0, period};
    assign trial      = {rem_reg, dvd_reg[tas_pkg::DvdW-1]};
    assign trial_ge   = (trial >= divisor);
    assign trial_diff = trial - divisor;

    // Segment boundaries within the period
    assign dr_sum = {1'b0, dwell_reg} + {1'b0, ramp_reg};
    assign end2   = {1'b0, dr_sum} + {2'b00, dwell_reg};

    always_comb
    begin
        cls_seg = tas_pkg::SEG_DWELL_START;
        cls_off = '0;
        if (rem_reg < {2'b00, dwell_reg})
        begin
            cls_seg = tas_pkg::SEG_DWELL_START;
        end
        else if (rem_reg < {1'b0, dr_sum})
        begin
            cls_seg = tas_pkg::SEG_RAMP_UP;
            cls_off = rem_reg - {2'b00, dwell_reg};
        end
        else if (rem_reg < end2)
        begin
            cls_seg = tas_pkg::SEG_DWELL_END;
        end
        else
        begin
            cls_seg = tas_pkg::SEG_RAMP_BACK;
            cls_off = rem_reg - end2;
        end
    end

    assign diff     = {end_reg[tas_pkg::AngleW-1], end_reg}
                    - {start_reg[tas_pkg::AngleW-1], start_reg};
    assign diff_abs = diff[tas_pkg::AngleW] ? (~diff + 1'b1) : diff;
    assign prod     = diff_abs[tas_pkg::TickW-1:0] * offset_reg;

    // Quotient sits in the low dividend bits after the ramp division
    assign part = neg_reg ? (~{1'b0, dvd_reg[tas_pkg::TickW-1:0]} + 1'b1)
                          : {1'b0, dvd_reg[tas_pkg::TickW-1:0]};

    always_comb
    begin
        case (seg_reg)
            tas_pkg::SEG_RAMP_UP:
                angle_sum = {start_reg[tas_pkg::AngleW-1], start_reg} + part;
            tas_pkg::SEG_DWELL_END:
                angle_sum = {end_reg[tas_pkg::AngleW-1], end_reg};
            tas_pkg::SEG_RAMP_BACK:
                angle_sum = {end_reg[tas_pkg::AngleW-1], end_reg} - part;
            default:
                angle_sum = {start_reg[tas_pkg::AngleW-1], start_reg};
        endcase
    end

    assign status.period_zero = (period == '0);
    assign status.ramp_hit    = cls_seg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            end_reg   <= '0;
            ramp_reg  <= tas_pkg::TickW'(1);
            dwell_reg <= '0;
            phase_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tas_pkg::REG_START_ANGLE: start_reg <= cfg_data;
                    tas_pkg::REG_END_ANGLE:   end_reg   <= cfg_data;
                    tas_pkg::REG_RAMP_TICKS:  ramp_reg  <= cfg_data;
                    tas_pkg::REG_DWELL_TICKS: dwell_reg <= cfg_data;
                    default:                  ;
                endcase
            end
            if (cmd.load && status.period_zero)
            begin
                phase_reg <= '0;
            end
            else if (cmd.classify)
            begin
                phase_reg <= rem_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg <= '0;
            dvd_reg <= {1'b0, phase_reg} + {3'b000, elapsed_ticks};
            seg_reg <= tas_pkg::SEG_DWELL_START;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial_diff[tas_pkg::PhaseW-1:0]
                                : trial[tas_pkg::PhaseW-1:0];
            dvd_reg <= {dvd_reg[tas_pkg::DvdW-2:0], trial_ge};
        end
        else if (cmd.mult)
        begin
            // High half stays below ramp_ticks since offset < ramp_ticks
            rem_reg <= {2'b00, prod[2*tas_pkg::TickW-1:tas_pkg::TickW]};
            dvd_reg <= {prod[tas_pkg::TickW-1:0], 3'b000};
            neg_reg <= diff[tas_pkg::AngleW];
        end
        if (cmd.classify)
        begin
            seg_reg    <= cls_seg;
            offset_reg <= cls_off[tas_pkg::TickW-1:0];
        end
        if (cmd.finish)
        begin
            angle_reg   <= angle_sum[tas_pkg::AngleW-1:0];
            out_seg_reg <= seg_reg;
        end
    end

    assign angle_out = angle_reg;
    assign segment   = out_seg_reg;

endmodule

### sv/tas_ctrl.sv
// ----------------------------------------------------------------------------
// tas_ctrl
// Sequencer for one request: phase modulo, classify, multiply, divide, output.
// ----------------------------------------------------------------------------
module tas_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  tas_pkg::dp_status_t  status,
    output tas_pkg::dp_cmd_t     cmd
);

    tas_pkg::state_t          state_reg;
    tas_pkg::state_t          state_next;
    logic [tas_pkg::CntW-1:0] cnt_reg;
    logic [tas_pkg::CntW-1:0] cnt_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            tas_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.period_zero ? tas_pkg::ST_FINISH
                                                    : tas_pkg::ST_MOD;
                    cnt_next   = tas_pkg::ModSteps - 1'b1;
                end
            end
            tas_pkg::ST_MOD:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = tas_pkg::ST_CLASSIFY;
                end
            end
            tas_pkg::ST_CLASSIFY:
            begin
                state_next = status.ramp_hit ? tas_pkg::ST_MULT : tas_pkg::ST_FINISH;
            end
            tas_pkg::ST_MULT:
            begin
                state_next = tas_pkg::ST_LERP;
                cnt_next   = tas_pkg::LerpSteps - 1'b1;
            end
            tas_pkg::ST_LERP:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = tas_pkg::ST_FINISH;
                end
            end
            tas_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = tas_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tas_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            tas_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            tas_pkg::ST_MOD:
            begin
                cmd.div_step = 1'b1;
            end
            tas_pkg::ST_CLASSIFY:
            begin
                cmd.classify = 1'b1;
            end
            tas_pkg::ST_MULT:
            begin
                cmd.mult = 1'b1;
            end
            tas_pkg::ST_LERP:
            begin
                cmd.div_step     = 1'b1;
                cmd.div_sel_ramp = 1'b1;
            end
            tas_pkg::ST_FINISH:
            begin
                cmd.finish = out_free;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tas_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### sv/trapezoid_angle_sweep_core.sv
// ----------------------------------------------------------------------------
// trapezoid_angle_sweep_core
// Trapezoidal angle generator: phase accumulator with dwell and linear ramps.
// ----------------------------------------------------------------------------
// Each input request adds elapsed_ticks to an 18-bit phase that wraps modulo
// the period 2*ramp_ticks + 2*dwell_ticks, then returns one angle and its
// segment (first dwell, ramp up, second dwell, ramp back). Ramp-up angles are
// start + (diff * offset) / ramp_ticks and ramp-back angles are end minus that
// share, truncated toward zero. One request is in flight at a time. The
// shared restoring divider runs 19 iterations for the phase modulo and 16
// for the ramp quotient, one bit a cycle. The result sits in an output
// register, so a new request is accepted while the previous result still
// waits for out_ready. Configuration writes take effect at once and belong
// to idle periods only; the user is bound to that, the core does not
// enforce it.
// ----------------------------------------------------------------------------
module trapezoid_angle_sweep_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_index,
    input  logic [tas_pkg::AngleW-1:0]         cfg_data,
    // request channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [tas_pkg::TickW-1:0]          elapsed_ticks,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [tas_pkg::AngleW-1:0]  angle_out,
    output logic [1:0]                         segment
);

    tas_pkg::dp_cmd_t    cmd;
    tas_pkg::dp_status_t status;
    logic [tas_pkg::AngleW-1:0] angle_bits;

    // Sequencer: walks one request through the datapath steps
    tas_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: config, phase, divider, multiplier, output register
    tas_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .elapsed_ticks (elapsed_ticks),
        .cmd           (cmd),
        .status        (status),
        .angle_out     (angle_bits),
        .segment       (segment)
    );

    // Angle is two's complement Q8.8
    assign angle_out = $signed(angle_bits);

endmodule

### sv/tas_checker.sv
// ----------------------------------------------------------------------------
// tas_checker
// Port-level checks of the trapezoid angle sweep core, bound to the top level.
// ----------------------------------------------------------------------------
module tas_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] angle_out,
    input logic [1:0]  segment
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(angle_out) && $stable(segment))
    else $error("result changed while stalled");

    // One request in flight: drop ready after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

    // A busy core cannot finish while the output register is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready && out_valid && !out_ready |=> !in_ready)
    else $error("core finished into a stalled output");

    // A new result comes only from a request in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
    else $error("result without a request in flight");

endmodule

bind trapezoid_angle_sweep_core tas_checker u_tas_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .angle_out (angle_out),
    .segment   (segment)
);

### verif/trapezoid_angle_sweep_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trapezoid_angle_sweep_core_tb
// Self-checking bench for the trapezoid angle sweep core.
// ----------------------------------------------------------------------------
// Drives elapsed-tick requests through the valid/ready input channel, tracks
// its own phase accumulator and register copy to predict the angle and
// segment of every request, and compares each returned result in order.
// Directed cases cover reset defaults, zero period, zero ramp, full-scale
// angles and ticks, a register change with the phase left beyond the new
// period, and output back-pressure. A random sweep then walks many register
// settings while both sides of the handshake idle and stall at random.
// ----------------------------------------------------------------------------
module trapezoid_angle_sweep_core_tb;

    // Cycle budget for the whole run before the bench gives up
    localparam int CycleLimit  = 500000;
    // Extra wait at the end, longer than the longest request takes
    localparam int DrainCycles = 60;
    localparam int HoldCycles  = 300;

    typedef struct packed {
        logic signed [tas_pkg::AngleW-1:0] angle;
        logic [1:0]                        seg;
    } sweep_point_t;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    logic [1:0]                         cfg_index;
    logic [tas_pkg::AngleW-1:0]         cfg_data;
    logic                               in_valid;
    logic                               in_ready;
    logic [tas_pkg::TickW-1:0]          elapsed_ticks;
    logic                               out_valid;
    logic                               out_ready;
    logic signed [tas_pkg::AngleW-1:0]  angle_out;
    logic [1:0]                         segment;

    // Local copy of the sweep registers and phase, updated as registers are written and requests go in
    logic signed [tas_pkg::AngleW-1:0]  sweep_start;
    logic signed [tas_pkg::AngleW-1:0]  sweep_end;
    logic [tas_pkg::TickW-1:0]          sweep_ramp;
    logic [tas_pkg::TickW-1:0]          sweep_dwell;
    logic [tas_pkg::PhaseW-1:0]         sweep_phase;

    // Angles and segments still owed by the core, oldest first
    sweep_point_t              expected_points[$];

    int fail_count;
    int cycle_count;
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_left;

    trapezoid_angle_sweep_core uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .elapsed_ticks (elapsed_ticks),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .angle_out     (angle_out),
        .segment       (segment)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Interpolated share of diff over the ramp; SV signed division truncates
    // toward zero, which is what the core must do too.
    function automatic int ramp_share(input int diff, input int unsigned offset,
                                      input int unsigned ramp);
        longint num;
        num = longint'(diff) * longint'(offset);
        return int'(num / longint'(ramp));
    endfunction

    // Advance the phase by one request and work out the angle it yields
    function automatic sweep_point_t predict_point(
        input logic [tas_pkg::TickW-1:0] ticks);
        int unsigned  ramp;
        int unsigned  dwell;
        int unsigned  period;
        int unsigned  t;
        int           start_v;
        int           end_v;
        int           diff;
        int           angle;
        logic [1:0]   seg;
        sweep_point_t pt;
        ramp    = sweep_ramp;
        dwell   = sweep_dwell;
        start_v = sweep_start;
        end_v   = sweep_end;
        diff    = end_v - start_v;
        period  = 2 * ramp + 2 * dwell;
        if (period == 0)
        begin
            // Zero period: pin the phase and hold the first angle
            sweep_phase = '0;
            angle       = start_v;
            seg         = tas_pkg::SEG_DWELL_START;
        end
        else
        begin
            // Phase may sit past a freshly shrunk period; the modulo folds it in
            t           = (32'(sweep_phase) + 32'(ticks)) % period;
            sweep_phase = t[tas_pkg::PhaseW-1:0];
            if (t < dwell)
            begin
                angle = start_v;
                seg   = tas_pkg::SEG_DWELL_START;
            end
            else if (t < dwell + ramp)
            begin
                angle = start_v + ramp_share(diff, t - dwell, ramp);
                seg   = tas_pkg::SEG_RAMP_UP;
            end
            else if (t < 2 * dwell + ramp)
            begin
                angle = end_v;
                seg   = tas_pkg::SEG_DWELL_END;
            end
            else
            begin
                angle = end_v - ramp_share(diff, t - 2 * dwell - ramp, ramp);
                seg   = tas_pkg::SEG_RAMP_BACK;
            end
        end
        pt.angle = angle[tas_pkg::AngleW-1:0];
        pt.seg   = seg;
        return pt;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offer one request, idling at random first; hold valid and payload
    // until the core takes it, then log the expected result.
    task automatic send_elapsed(input logic [tas_pkg::TickW-1:0] ticks);
        sweep_point_t pt;
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        elapsed_ticks <= ticks;
        do
            @(posedge clk);
        while (!in_ready);
        pt = predict_point(ticks);
        expected_points.insert(expected_points.size(), pt);
    endtask

    // Drop valid after the last request of a burst
    task automatic sender_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_results_drained();
        while (expected_points.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx,
                             input logic [tas_pkg::AngleW-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            tas_pkg::REG_START_ANGLE: sweep_start = val;
            tas_pkg::REG_END_ANGLE:   sweep_end   = val;
            tas_pkg::REG_RAMP_TICKS:  sweep_ramp  = val;
            tas_pkg::REG_DWELL_TICKS: sweep_dwell = val;
            default: ;
        endcase
    endtask

    // Stop offering, let every owed result come back, then rewrite all
    // four registers while the core sits idle.
    task automatic set_sweep(input logic signed [tas_pkg::AngleW-1:0] start_angle,
                             input logic signed [tas_pkg::AngleW-1:0] end_angle,
                             input logic [tas_pkg::TickW-1:0] ramp,
                             input logic [tas_pkg::TickW-1:0] dwell);
        sender_quiet();
        wait_results_drained();
        write_reg(tas_pkg::REG_START_ANGLE, start_angle);
        write_reg(tas_pkg::REG_END_ANGLE, end_angle);
        write_reg(tas_pkg::REG_RAMP_TICKS, ramp);
        write_reg(tas_pkg::REG_DWELL_TICKS, dwell);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // Receiver: a pending hold-off wins, otherwise stall at random
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                out_ready <= 1'b0;
                rx_hold_left--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Match every returned angle against the oldest prediction
    always @(posedge clk)
    begin : check_points
        sweep_point_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_points.size() == 0)
            begin
                $error("unexpected result: angle_out %0d segment %0d", angle_out, segment);
                fail_count++;
            end
            else
            begin
                want = expected_points.pop_front();
                if (angle_out !== want.angle)
                begin
                    $error("angle_out mismatch: expected %0d, got %0d", want.angle, angle_out);
                    fail_count++;
                end
                if (segment !== want.seg)
                begin
                    $error("segment mismatch: expected %0d, got %0d", want.seg, segment);
                    fail_count++;
                end
            end
        end
    end

    // Hard stop if the run hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Registers untouched since reset: ramp of one tick, no dwell, period two
    task automatic test_reset_defaults();
        send_elapsed(16'd0);
        send_elapsed(16'd1);
        send_elapsed(16'hFFFF);
        send_elapsed(16'd1);
    endtask

    // Zero ramp and zero dwell: the phase is pinned, first angle comes back
    task automatic test_zero_period();
        set_sweep(16'sh8000, 16'sh7FFF, 16'd0, 16'd0);
        send_elapsed(16'hFFFF);
        send_elapsed(16'd12345);
    endtask

    // Full-scale angles and the longest period; walk each segment edge
    task automatic test_ramp_extremes();
        set_sweep(16'sh8000, 16'sh7FFF, 16'hFFFF, 16'hFFFF);
        send_elapsed(16'hFFFF);   // start of ramp up
        send_elapsed(16'hFFFE);   // last tick of ramp up
        send_elapsed(16'd1);      // start of second dwell
        send_elapsed(16'hFFFF);   // start of ramp back
        send_elapsed(16'hFFFE);   // last tick of ramp back
        send_elapsed(16'd1);      // wrap to phase zero
    endtask

    // No ramp: only the two dwell segments are reachable
    task automatic test_zero_ramp();
        set_sweep(16'sd1234, -16'sd4321, 16'd0, 16'd5);
        send_elapsed(16'd3);
        send_elapsed(16'd4);
        send_elapsed(16'd3);
        send_elapsed(16'hFFFF);
    endtask

    // Leave the phase deep in a long period, then shrink the period under it;
    // falling ramp checks truncation toward zero on negative shares
    task automatic test_config_midrun();
        set_sweep(16'sd1000, -16'sd1000, 16'd40000, 16'd40000);
        send_elapsed(16'hFFFF);
        send_elapsed(16'hFFFF);
        set_sweep(16'sd1000, -16'sd1000, 16'd3, 16'd2);
        send_elapsed(16'd0);
        send_elapsed(16'd3);
        send_elapsed(16'd5);
    endtask

    // Hold the result side off while requests keep coming, so the output
    // register fills and the core stops taking requests
    task automatic test_output_backpressure();
        int i;
        set_sweep(-16'sd2560, 16'sd7680, 16'd7, 16'd3);
        @(posedge clk);
        rx_hold_left = HoldCycles;
        tx_idle_pct  = 0;
        for (i = 0; i < 12; i++)
            send_elapsed(16'($urandom_range(0, 25)));
        tx_idle_pct = 30;
    endtask

    // Many register settings, each followed by a burst of random requests.
    // Where the period is nonzero, most ticks are no larger than it so every segment gets visited.
    task automatic test_random_sweep();
        int                                p;
        int                                i;
        int                                burst;
        int unsigned                       period;
        logic signed [tas_pkg::AngleW-1:0] a0;
        logic signed [tas_pkg::AngleW-1:0] a1;
        logic [tas_pkg::TickW-1:0]         ramp;
        logic [tas_pkg::TickW-1:0]         dwell;
        for (p = 0; p < 20; p++)
        begin
            case ($urandom_range(0, 4))
                0:
                begin
                    ramp  = 16'($urandom_range(0, 6));
                    dwell = 16'($urandom_range(0, 6));
                end
                1:
                begin
                    ramp  = 16'($urandom_range(1, 3000));
                    dwell = 16'($urandom_range(0, 3000));
                end
                2:
                begin
                    ramp  = 16'($urandom_range(0, 65535));
                    dwell = 16'($urandom_range(0, 65535));
                end
                3:
                begin
                    case ($urandom_range(0, 2))
                        0:       ramp = 16'd0;
                        1:       ramp = 16'd1;
                        default: ramp = 16'hFFFF;
                    endcase
                    dwell = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
                end
                default:
                begin
                    ramp  = 16'd0;
                    dwell = 16'($urandom_range(0, 20));
                end
            endcase
            if ($urandom_range(0, 3) == 0)
            begin
                a0 = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
                a1 = ~a0;
            end
            else
            begin
                a0 = 16'($urandom_range(0, 65535));
                a1 = 16'($urandom_range(0, 65535));
            end
            set_sweep(a0, a1, ramp, dwell);
            period = 2 * 32'(ramp) + 2 * 32'(dwell);

            // One long burst runs with neither side idling
            burst = 30;
            if (p == 5)
            begin
                burst       = 60;
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (i = 0; i < burst; i++)
            begin
                if (period != 0 && $urandom_range(0, 9) < 6)
                    send_elapsed(16'($urandom_range(0, (period > 65535) ? 65535 : period)));
                else
                    send_elapsed(16'($urandom_range(0, 65535)));
            end
            tx_idle_pct = 30;
            rx_idle_pct = 30;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        fail_count    = 0;
        cycle_count   = 0;
        tx_idle_pct   = 30;
        rx_idle_pct   = 30;
        rx_hold_left  = 0;
        cfg_we        = 1'b0;
        cfg_index     = tas_pkg::REG_START_ANGLE;
        cfg_data      = '0;
        in_valid      = 1'b0;
        elapsed_ticks = '0;
        // Reset state of the local copy
        sweep_start   = '0;
        sweep_end     = '0;
        sweep_ramp    = 16'd1;
        sweep_dwell   = '0;
        sweep_phase   = '0;

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_zero_period();
        test_ramp_extremes();
        test_zero_ramp();
        test_config_midrun();
        test_output_backpressure();
        test_random_sweep();

        // Let the last results come home and make sure nothing extra follows
        sender_quiet();
        wait_results_drained();
        repeat (DrainCycles) @(posedge clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### trapezoid_angle_sweep_core.f
sv/tas_pkg.sv
sv/tas_datapath.sv
sv/tas_ctrl.sv
sv/trapezoid_angle_sweep_core.sv
sv/tas_checker.sv
verif/trapezoid_angle_sweep_core_tb.sv
